[src/fos_pkg.sv]
// ----------------------------------------------------------------------------
// fos_pkg
// Shared types, widths, register codes and helpers for the fuzzy obstacle
// steering block.
// ----------------------------------------------------------------------------
package fos_pkg;

	localparam int ECHO_W        = 15;
	localparam int DIST_W        = 13;
	localparam int CFG_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int DIR_W         = 14;
	localparam int DIR_FRAC_BITS = 12;
	localparam int DIR_QUO_W     = DIR_FRAC_BITS + 2;
	localparam int DIST_SCALE    = 17983;
	localparam int SCALE_W       = 15;
	localparam int PROD_W        = ECHO_W + SCALE_W;
	localparam int ROUND_SHIFT   = 16;
	localparam int LANES         = 3;

	localparam int FRAC_BITS_DEFAULT    = 12;
	localparam int ECHO_TIMEOUT_DEFAULT = 30000;
	localparam int QUEUE_DEPTH_DEFAULT  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_RAMP_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 2'd3;

	localparam logic [CFG_W-1:0] RAMP_START_RESET = 9'd30;
	localparam logic [CFG_W-1:0] RAMP_END_RESET   = 9'd40;
	localparam logic [CFG_W-1:0] MIN_VALID_RESET  = 9'd2;
	localparam logic [CFG_W-1:0] MAX_RANGE_RESET  = 9'd400;

	typedef struct packed {
		logic [ECHO_W-1:0] left_echo_us;
		logic [ECHO_W-1:0] center_echo_us;
		logic [ECHO_W-1:0] right_echo_us;
	} in_item_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] direction_q12;
		logic                    left_motor_on;
		logic                    right_motor_on;
		logic                    no_rule_fired;
		logic [DIST_W-1:0]       left_distance;
		logic [DIST_W-1:0]       center_distance;
		logic [DIST_W-1:0]       right_distance;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] ramp_start_cm;
		logic [CFG_W-1:0] ramp_end_cm;
		logic [CFG_W-1:0] min_valid_cm;
		logic [CFG_W-1:0] max_range_cm;
	} cfg_t;

	// lane 0 left, 1 center, 2 right
	typedef logic [LANES-1:0][DIST_W-1:0] dist_set_t;

	function automatic logic [DIST_W-1:0] cm_to_sixteenths(input logic [CFG_W-1:0] cm);
		return {cm, 4'b0000};
	endfunction

endpackage

[src/fos_div.sv]
// ----------------------------------------------------------------------------
// fos_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Requires num < den * 2^QW.
// ----------------------------------------------------------------------------
module fos_div #(
	parameter int DW = 13,
	parameter int QW = 13,
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0]    den,
	input  logic [TW-1:0]    tag_in,
	output logic             out_valid,
	output logic [QW-1:0]    quo,
	output logic [TW-1:0]    tag_out
);
	localparam int W = DW + QW;

	logic          vld_q [QW];
	logic [W-1:0]  rem_q [QW-1];
	logic [DW-1:0] den_q [QW-1];
	logic [QW-1:0] quo_q [QW];
	logic [TW-1:0] tag_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          v_in;
		logic [W-1:0]  r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [TW-1:0] t_in;
		logic [W-1:0]  dsh;
		logic [W:0]    trial;

		if (k == 0) begin : g_head
			assign v_in = in_valid;
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign t_in = tag_in;
		end else begin : g_body
			assign v_in = vld_q[k-1];
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
			assign t_in = tag_q[k-1];
		end

		assign dsh   = W'(d_in) << (QW - 1 - k);
		assign trial = {1'b0, r_in} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= q_in | (QW'(!trial[W]) << (QW - 1 - k));
				tag_q[k] <= t_in;
			end
		end

		if (k < QW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= trial[W] ? r_in : trial[W-1:0];
					den_q[k] <= d_in;
				end
			end
		end
	end

	assign out_valid = vld_q[QW-1];
	assign quo       = quo_q[QW-1];
	assign tag_out   = tag_q[QW-1];

endmodule

[src/fos_front.sv]
// ----------------------------------------------------------------------------
// fos_front
// Input side: scales echo times to distances in 1/16 cm and replaces timed
// out or out-of-range readings with the maximum range.
// ----------------------------------------------------------------------------
module fos_front #(
	parameter int ECHO_TIMEOUT_US = fos_pkg::ECHO_TIMEOUT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fos_pkg::in_item_t  in_item,
	input  fos_pkg::cfg_t      cfg,
	input  logic               queue_full,
	output logic               push,
	output fos_pkg::dist_set_t push_data
);
	import fos_pkg::*;

	localparam int RAW_W = PROD_W - ROUND_SHIFT + 1;
	localparam logic [ECHO_W-1:0] TIMEOUT = ECHO_W'(ECHO_TIMEOUT_US);
	localparam logic [PROD_W:0] ROUND_BIAS = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);

	logic [LANES-1:0][ECHO_W-1:0] echo;
	logic                         adv;
	logic                         valid_s1;
	logic                         valid_s2;
	logic [LANES-1:0][PROD_W-1:0] prod_s1;
	logic [LANES-1:0]             bad_s1;
	dist_set_t                    dist_s2;
	dist_set_t                    dist_c;
	logic [LANES-1:0][PROD_W:0]   biased;
	logic [LANES-1:0][RAW_W-1:0]  raw;
	logic [DIST_W-1:0]            maxd;
	logic [DIST_W-1:0]            mind;

	assign echo     = {in_item.right_echo_us, in_item.center_echo_us, in_item.left_echo_us};
	assign adv      = !(valid_s2 && queue_full);
	assign in_stall = !adv;
	assign maxd     = cm_to_sixteenths(cfg.max_range_cm);
	assign mind     = cm_to_sixteenths(cfg.min_valid_cm);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			biased[i] = (PROD_W + 1)'(prod_s1[i]) + ROUND_BIAS;
			raw[i]    = biased[i][PROD_W:ROUND_SHIFT];
			if (bad_s1[i] || raw[i] < RAW_W'(mind) || raw[i] > RAW_W'(maxd)) begin
				dist_c[i] = maxd;
			end else begin
				dist_c[i] = raw[i][DIST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= PROD_W'(echo[i]) * PROD_W'(DIST_SCALE);
				bad_s1[i]  <= (echo[i] == '0) || (echo[i] > TIMEOUT);
			end
			dist_s2 <= dist_c;
		end
	end

	assign push      = valid_s2 && !queue_full;
	assign push_data = dist_s2;

endmodule

[src/fos_queue.sv]
// ----------------------------------------------------------------------------
// fos_queue
// Short queue of distance sets between the front and back parts.
// ----------------------------------------------------------------------------
module fos_queue #(
	parameter int DEPTH = fos_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fos_pkg::dist_set_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output fos_pkg::dist_set_t head
);
	import fos_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dist_set_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/fos_back.sv]
// ----------------------------------------------------------------------------
// fos_back
// Rule evaluation: ramp memberships, eight min-rules, weighted average of
// the rule directions and motor thresholds.
// ----------------------------------------------------------------------------
module fos_back #(
	parameter int FRAC_BITS = fos_pkg::FRAC_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fos_pkg::cfg_t      cfg,
	input  logic               queue_empty,
	input  fos_pkg::dist_set_t queue_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output fos_pkg::out_item_t out_item
);
	import fos_pkg::*;

	localparam int MW      = FRAC_BITS + 1;
	localparam int ODW     = DIST_W;
	localparam int OQW     = FRAC_BITS + 1;
	localparam int ONW     = ODW + OQW;
	localparam int OTAG_W  = DIST_W + 2;
	localparam int SUM_W   = FRAC_BITS + 4;
	localparam int NUM_W   = FRAC_BITS + 6;
	localparam int MAG_W   = FRAC_BITS + 5;
	localparam int CMP_W   = FRAC_BITS + 8;
	localparam int DDW     = SUM_W + 1;
	localparam int DQW     = DIR_QUO_W;
	localparam int DNW     = DDW + DQW;
	localparam int DTAG_W  = 4 + LANES * DIST_W;
	localparam int RULES   = 8;
	localparam int NEG_LIMIT = (1 << FRAC_BITS) / 10000;

	localparam logic [MW-1:0]    ONE     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(NEG_LIMIT);

	function automatic logic [MW-1:0] min3(input logic [MW-1:0] a, input logic [MW-1:0] b,
		input logic [MW-1:0] c);
		logic [MW-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	logic en;

	// stage 1: divider operands per lane
	logic [DIST_W-1:0]             ramp_s;
	logic [DIST_W-1:0]             ramp_e;
	logic [DIST_W-1:0]             span;
	logic [LANES-1:0][ONW-1:0]     onum_c;
	logic [LANES-1:0][OTAG_W-1:0]  otag_c;
	logic                          valid_s1;
	logic [LANES-1:0][ONW-1:0]     onum_s1;
	logic [DIST_W-1:0]             oden_s1;
	logic [LANES-1:0][OTAG_W-1:0]  otag_s1;

	// lane divider outputs
	logic [LANES-1:0]              lane_valid;
	logic [LANES-1:0][OQW-1:0]     lane_quo;
	logic [LANES-1:0][OTAG_W-1:0]  lane_tag;

	// stage 2: rule weights
	logic [LANES-1:0][MW-1:0]      obs;
	logic [LANES-1:0][MW-1:0]      fre;
	dist_set_t                     lane_dist;
	logic [RULES-1:0][MW-1:0]      weight_c;
	logic                          valid_s2;
	logic [RULES-1:0][MW-1:0]      weight_s2;
	dist_set_t                     dist_s2;

	// stage 3: weight sum and signed numerator
	logic [SUM_W-1:0]              sum_c;
	logic [NUM_W-1:0]              num_c;
	logic                          valid_s3;
	logic [SUM_W-1:0]              sum_s3;
	logic signed [NUM_W-1:0]       num_s3;
	dist_set_t                     dist_s3;

	// stage 4: direction divider operands and motor decision
	logic                          neg;
	logic                          no_fire;
	logic [NUM_W-1:0]              mag_full;
	logic [MAG_W-1:0]              mag;
	logic signed [CMP_W-1:0]       n2;
	logic signed [CMP_W-1:0]       s1x;
	logic signed [CMP_W-1:0]       s3x;
	logic                          lm;
	logic                          rm;
	logic                          valid_s4;
	logic [DNW-1:0]                dnum_s4;
	logic [DDW-1:0]                dden_s4;
	logic [DTAG_W-1:0]             dtag_s4;

	// direction divider outputs and result
	logic                          dir_valid;
	logic [DQW-1:0]                dir_quo;
	logic [DTAG_W-1:0]             dir_tag;
	logic [DIR_W-1:0]              dir_val;
	out_item_t                     out_c;
	logic                          out_valid_q;
	out_item_t                     out_item_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !queue_empty;

	assign ramp_s = cm_to_sixteenths(cfg.ramp_start_cm);
	assign ramp_e = cm_to_sixteenths(cfg.ramp_end_cm);
	assign span   = ramp_e - ramp_s;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			onum_c[i] = ONW'({ramp_e - queue_head[i], {FRAC_BITS{1'b0}}})
				+ ONW'(span[DIST_W-1:1]);
			otag_c[i] = {queue_head[i], queue_head[i] <= ramp_s, queue_head[i] >= ramp_e};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= !queue_empty;
			valid_s2 <= &lane_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			onum_s1 <= onum_c;
			oden_s1 <= span;
			otag_s1 <= otag_c;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		fos_div #(
			.DW(ODW),
			.QW(OQW),
			.TW(OTAG_W)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (valid_s1),
			.num      (onum_s1[i]),
			.den      (oden_s1),
			.tag_in   (otag_s1[i]),
			.out_valid(lane_valid[i]),
			.quo      (lane_quo[i]),
			.tag_out  (lane_tag[i])
		);
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_dist[i] = lane_tag[i][OTAG_W-1:2];
			if (lane_tag[i][1]) begin
				obs[i] = ONE;
			end else if (lane_tag[i][0]) begin
				obs[i] = '0;
			end else begin
				obs[i] = lane_quo[i];
			end
			fre[i] = ONE - obs[i];
		end
		weight_c[0] = min3(fre[0], fre[1], fre[2]); // straight
		weight_c[1] = min3(obs[0], fre[1], fre[2]); // right
		weight_c[2] = min3(fre[0], fre[1], obs[2]); // left
		weight_c[3] = min3(obs[0], fre[1], obs[2]); // straight
		weight_c[4] = min3(fre[0], obs[1], fre[2]); // stop
		weight_c[5] = min3(obs[0], obs[1], fre[2]); // right
		weight_c[6] = min3(fre[0], obs[1], obs[2]); // left
		weight_c[7] = min3(obs[0], obs[1], obs[2]); // stop
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s2 <= weight_c;
			dist_s2   <= lane_dist;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < RULES; i++) begin
			sum_c = sum_c + SUM_W'(weight_s2[i]);
		end
		num_c = NUM_W'(weight_s2[1]) + NUM_W'(weight_s2[5])
			- NUM_W'(weight_s2[2]) - NUM_W'(weight_s2[6])
			- ((NUM_W'(weight_s2[4]) + NUM_W'(weight_s2[7])) << 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_c;
			num_s3  <= num_c;
			dist_s3 <= dist_s2;
		end
	end

	always_comb begin
		no_fire  = (sum_s3 <= NEG_LIM);
		neg      = num_s3[NUM_W-1];
		mag_full = neg ? (NUM_W'(0) - num_s3) : num_s3;
		mag      = mag_full[MAG_W-1:0];
		n2       = {{(CMP_W - NUM_W - 1){num_s3[NUM_W-1]}}, num_s3, 1'b0};
		s1x      = {{(CMP_W - SUM_W){1'b0}}, sum_s3};
		s3x      = s1x + (s1x <<< 1);
		if (no_fire) begin
			lm = 1'b1;
			rm = 1'b1;
		end else if (n2 < -s3x) begin
			lm = 1'b0;
			rm = 1'b0;
		end else if (n2 < -s1x) begin
			lm = 1'b0;
			rm = 1'b1;
		end else if (n2 < s1x) begin
			lm = 1'b1;
			rm = 1'b1;
		end else begin
			lm = 1'b1;
			rm = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dnum_s4 <= DNW'({mag, {(DIR_FRAC_BITS + 1){1'b0}}}) + DNW'(sum_s3);
			dden_s4 <= {sum_s3, 1'b0};
			dtag_s4 <= {neg, no_fire, lm, rm, dist_s3};
		end
	end

	fos_div #(
		.DW(DDW),
		.QW(DQW),
		.TW(DTAG_W)
	) u_dir_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.num      (dnum_s4),
		.den      (dden_s4),
		.tag_in   (dtag_s4),
		.out_valid(dir_valid),
		.quo      (dir_quo),
		.tag_out  (dir_tag)
	);

	always_comb begin
		if (dir_tag[DTAG_W-2]) begin
			dir_val = '0;
		end else if (dir_tag[DTAG_W-1]) begin
			dir_val = DIR_W'(DQW'(0) - dir_quo);
		end else begin
			dir_val = DIR_W'(dir_quo);
		end
		out_c.direction_q12   = dir_val;
		out_c.left_motor_on   = dir_tag[DTAG_W-3];
		out_c.right_motor_on  = dir_tag[DTAG_W-4];
		out_c.no_rule_fired   = dir_tag[DTAG_W-2];
		out_c.left_distance   = dir_tag[DIST_W-1:0];
		out_c.center_distance = dir_tag[2*DIST_W-1:DIST_W];
		out_c.right_distance  = dir_tag[3*DIST_W-1:2*DIST_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q <= out_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[src/fuzzy_obstacle_steering.sv]
// ----------------------------------------------------------------------------
// fuzzy_obstacle_steering
// Zero-order fuzzy steering from three ultrasonic echo times.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  in_item  (three echo times)
//   out       output     out_valid/out_stall out_item (direction, motors, dist)
//   cfg       input      cfg_write          cfg_index, cfg_data
//
// sustained rate is one item per cycle while out_stall is low; the path
// runs through the two restoring divider pipelines (membership ramp and
// weighted average), one quotient bit per stage. reset clears all valid
// state and loads the register defaults. out_stall freezes the back part
// only; the queue takes QUEUE_DEPTH items before in_stall rises.
// ----------------------------------------------------------------------------
module fuzzy_obstacle_steering #(
	parameter int MEMBERSHIP_FRAC_BITS = fos_pkg::FRAC_BITS_DEFAULT,
	parameter int ECHO_TIMEOUT_US      = fos_pkg::ECHO_TIMEOUT_DEFAULT,
	parameter int QUEUE_DEPTH          = fos_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fos_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fos_pkg::out_item_t              out_item,
	input  logic                            cfg_write,
	input  logic [fos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fos_pkg::CFG_W-1:0]       cfg_data
);
	import fos_pkg::*;

	cfg_t      cfg_q;
	logic      queue_full;
	logic      queue_empty;
	logic      push;
	logic      pop;
	dist_set_t push_data;
	dist_set_t queue_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_start_cm <= RAMP_START_RESET;
			cfg_q.ramp_end_cm   <= RAMP_END_RESET;
			cfg_q.min_valid_cm  <= MIN_VALID_RESET;
			cfg_q.max_range_cm  <= MAX_RANGE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RAMP_START: cfg_q.ramp_start_cm <= cfg_data;
				REG_RAMP_END:   cfg_q.ramp_end_cm   <= cfg_data;
				REG_MIN_VALID:  cfg_q.min_valid_cm  <= cfg_data;
				REG_MAX_RANGE:  cfg_q.max_range_cm  <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fos_front #(
		.ECHO_TIMEOUT_US(ECHO_TIMEOUT_US)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	fos_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (queue_head)
	);

	fos_back #(
		.FRAC_BITS(MEMBERSHIP_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.queue_empty(queue_empty),
		.queue_head (queue_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
